@@ rtl/core/dps_pkg.sv @@
`timescale 1ns / 1ps
package dps_pkg;

  localparam int NUM_STATES = 256;
  localparam int NUM_DFAS   = 2;
  localparam int NUM_SYMS   = 256;

  localparam int STATE_W = 8;   // width of a state as carried in the item fields
  localparam int IDX_W   = $clog2(NUM_STATES);
  localparam int DFA_W   = $clog2(NUM_DFAS);
  localparam int SYM_W   = $clog2(NUM_SYMS);
  localparam int USED_W  = 9;
  localparam int CNT_W   = 8;

  localparam int TRANS_DEPTH = NUM_DFAS * NUM_STATES * NUM_SYMS;
  localparam int MATCH_DEPTH = NUM_DFAS * NUM_STATES;

  localparam logic [2:0] MODE_WR_TRANS = 3'd0;
  localparam logic [2:0] MODE_WR_MATCH = 3'd1;
  localparam logic [2:0] MODE_WR_USED  = 3'd2;
  localparam logic [2:0] MODE_START    = 3'd3;
  localparam logic [2:0] MODE_SCAN     = 3'd4;

  typedef struct packed {
    logic [2:0]         mode;
    logic [DFA_W-1:0]   dfa_index;
    logic [STATE_W-1:0] entry_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] next_state;
    logic [CNT_W-1:0]   match_count;
    logic [USED_W-1:0]  used_states;
    logic [SYM_W-1:0]   data_byte;
    logic               last_byte;
  } in_item_t;

  typedef struct packed {
    logic               alert;
    logic [STATE_W-1:0] dfa_state;
    logic [CNT_W-1:0]   matched;
    logic               packet_stopped;
  } out_item_t;

  // Per-flow scan context
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               alert;
    logic [DFA_W-1:0]   active_dfa;
    logic               at_start;
    logic               skip;
  } scan_state_t;

  localparam scan_state_t ST_RESET = '{
    state: '0, alert: 1'b0, active_dfa: '0, at_start: 1'b1, skip: 1'b0
  };

endpackage

@@ rtl/core/dps_ram.sv @@
`timescale 1ns / 1ps
module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/dps_step.sv @@
`timescale 1ns / 1ps
module dps_step (
  input  dps_pkg::scan_state_t              cur,
  input  dps_pkg::in_item_t                 item,
  input  logic [dps_pkg::USED_W-1:0]        used_lim,
  input  logic [dps_pkg::CNT_W-1:0]         match_rdata,
  input  logic [dps_pkg::STATE_W-1:0]       trans_rdata,
  output dps_pkg::scan_state_t              post,
  output dps_pkg::out_item_t                res
);

  logic                         in_range;
  logic                         dfa_ok;
  logic                         stopped;
  logic [dps_pkg::CNT_W-1:0]    cnt;
  logic [dps_pkg::CNT_W-1:0]    matched;
  logic [dps_pkg::STATE_W-1:0]  ns;

  always_comb begin
    post     = cur;
    stopped  = cur.skip;
    matched  = '0;
    in_range = {1'b0, cur.state} < dps_pkg::USED_W'(dps_pkg::NUM_STATES);
    dfa_ok   = {1'b0, item.dfa_index} < (dps_pkg::DFA_W + 1)'(dps_pkg::NUM_DFAS);
    cnt      = in_range ? match_rdata : '0;
    ns       = in_range ? trans_rdata : '0;

    unique case (item.mode)
      dps_pkg::MODE_START: begin
        post.active_dfa = dfa_ok ? item.dfa_index : dps_pkg::DFA_W'(dps_pkg::NUM_DFAS - 1);
        post.state      = '0;
        post.alert      = 1'b0;
        post.at_start   = 1'b1;
        post.skip       = 1'b0;
        stopped         = 1'b0;
      end
      dps_pkg::MODE_SCAN: begin
        // first byte of a packet: a state beyond the loaded range drops the packet
        if (!cur.skip && cur.at_start) begin
          post.at_start = 1'b0;
          if ({1'b0, cur.state} >= used_lim) begin
            post.alert = 1'b0;
            post.skip  = 1'b1;
          end
        end
        if (!post.skip) begin
          if (cnt != '0) begin
            post.alert = 1'b1;
            post.skip  = 1'b1;
            matched    = cnt;
          end else begin
            post.state = ns;
          end
        end
        stopped = post.skip;
        if (item.last_byte) begin
          post.at_start = 1'b1;
          post.skip     = 1'b0;
        end
      end
      default: begin
      end
    endcase

    res.alert          = post.alert;
    res.dfa_state      = post.state;
    res.matched        = matched;
    res.packet_stopped = stopped;
  end

endmodule

@@ rtl/core/dfa_pattern_scanner_unit.sv @@
`timescale 1ns / 1ps
// DFA pattern scanner: one flow, several loadable automata.
// Input channel (in_valid/in_ready/in_data) carries table loads, flow starts
// and payload bytes; output channel (out_valid/out_ready/out_data) returns one
// result per input item, in order.
// An accepted item is registered into the lookup stage (item and RAM read),
// and its result is then registered on out_data when the output can take it.
// Throughput: one item per cycle while the output is not stalled.
// Each scan byte reads the transition and match tables at the address formed
// from the state left by the byte before it; that state comes straight off the
// previous read's registered RAM output, so the loop RAM -> step logic -> RAM
// read address sets the cycle.
// Table loads are written at the transfer edge, so a following byte sees them.
// Reset clears the scan context (state 0, alert low, automaton 0, packet start)
// and empties the pipeline; table contents are not cleared and must be loaded.
// When the receiver stalls, the result holds in the output register, one more
// item may be accepted into the lookup stage, then in_ready drops.
module dfa_pattern_scanner_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dps_pkg::out_item_t out_data
);

  localparam int TRANS_AW = $clog2(dps_pkg::TRANS_DEPTH);
  localparam int MATCH_AW = $clog2(dps_pkg::MATCH_DEPTH);

  dps_pkg::scan_state_t st;
  dps_pkg::scan_state_t post;
  dps_pkg::scan_state_t fwd;
  dps_pkg::in_item_t    s1_item;
  dps_pkg::out_item_t   res;
  logic                 s1_valid;
  logic                 s1_fire;
  logic                 in_fire;
  logic                 dfa_ok;
  logic                 est_ok;

  logic [dps_pkg::USED_W-1:0]  used_limit [dps_pkg::NUM_DFAS];
  logic [dps_pkg::USED_W-1:0]  used_clamped;
  logic [dps_pkg::CNT_W-1:0]   match_rdata;
  logic [dps_pkg::STATE_W-1:0] trans_rdata;

  logic                trans_we;
  logic                match_we;
  logic [TRANS_AW-1:0] trans_waddr;
  logic [TRANS_AW-1:0] trans_raddr;
  logic [MATCH_AW-1:0] match_waddr;
  logic [MATCH_AW-1:0] match_raddr;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  dps_step u_step (
    .cur         (st),
    .item        (s1_item),
    .used_lim    (used_limit[st.active_dfa]),
    .match_rdata (match_rdata),
    .trans_rdata (trans_rdata),
    .post        (post),
    .res         (res)
  );

  // context seen by the item entering now: bypass the one still in lookup
  assign fwd = s1_valid ? post : st;

  assign dfa_ok = {1'b0, in_data.dfa_index} < (dps_pkg::DFA_W + 1)'(dps_pkg::NUM_DFAS);
  assign est_ok = {1'b0, in_data.entry_state} < dps_pkg::USED_W'(dps_pkg::NUM_STATES);

  assign trans_we    = in_fire && (in_data.mode == dps_pkg::MODE_WR_TRANS) && dfa_ok && est_ok;
  assign match_we    = in_fire && (in_data.mode == dps_pkg::MODE_WR_MATCH) && dfa_ok && est_ok;
  assign trans_waddr = {in_data.dfa_index, in_data.entry_state[dps_pkg::IDX_W-1:0],
                        in_data.symbol};
  assign match_waddr = {in_data.dfa_index, in_data.entry_state[dps_pkg::IDX_W-1:0]};
  assign trans_raddr = {fwd.active_dfa, fwd.state[dps_pkg::IDX_W-1:0], in_data.data_byte};
  assign match_raddr = {fwd.active_dfa, fwd.state[dps_pkg::IDX_W-1:0]};

  assign used_clamped = (in_data.used_states > dps_pkg::USED_W'(dps_pkg::NUM_STATES)) ?
                        dps_pkg::USED_W'(dps_pkg::NUM_STATES) : in_data.used_states;

  dps_ram #(
    .WIDTH (dps_pkg::STATE_W),
    .DEPTH (dps_pkg::TRANS_DEPTH)
  ) u_trans_ram (
    .clk     (clk),
    .wr_en   (trans_we),
    .wr_addr (trans_waddr),
    .wr_data (in_data.next_state),
    .rd_en   (in_fire),
    .rd_addr (trans_raddr),
    .rd_data (trans_rdata)
  );

  dps_ram #(
    .WIDTH (dps_pkg::CNT_W),
    .DEPTH (dps_pkg::MATCH_DEPTH)
  ) u_match_ram (
    .clk     (clk),
    .wr_en   (match_we),
    .wr_addr (match_waddr),
    .wr_data (in_data.match_count),
    .rd_en   (in_fire),
    .rd_addr (match_raddr),
    .rd_data (match_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= dps_pkg::ST_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        st <= post;
      end
      if (in_ready) begin
        s1_valid <= in_fire;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_data;
    end
    if (s1_fire) begin
      out_data <= res;
    end
    if (in_fire && (in_data.mode == dps_pkg::MODE_WR_USED) && dfa_ok) begin
      used_limit[in_data.dfa_index] <= used_clamped;
    end
  end

endmodule

@@ rtl/core/dps_checker.sv @@
`timescale 1ns / 1ps
module dps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input dps_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side stalls only under output backpressure
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // a match always raises the alert and stops the packet
  a_match_alert: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.matched != '0) |-> out_data.alert && out_data.packet_stopped)
    else $error("match reported without alert or stop");

  // an idle pipeline reports nothing the cycle after a reset edge
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind dfa_pattern_scanner_unit dps_checker u_dps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
